FILE: rtl/core/gcd_pkg.sv
// Shared types, constants and arctangent table for the great-circle distance unit.
`default_nettype none

package gcd_pkg;

   localparam int TrigIterationsDef = 24;
   localparam int SqrtSteps = 31;

   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [33:0] HALF_PI_Q30     = 34'sd1686629713;
   localparam logic signed [32:0] ONE_Q30         = 33'sd1073741824;

   localparam logic signed [32:0] DEG_QUARTER = 33'sd377487360;
   localparam logic signed [32:0] DEG_HALF    = 33'sd754974720;
   localparam logic signed [32:0] DEG_FULL    = 33'sd1509949440;

   // Degrees-to-radians factor split as 4 * 2^32 + low word.
   localparam logic [31:0] DEG2RAD_LO = 32'd2010228885;
   localparam logic [28:0] RADIUS_KM_Q16 = 29'd417997586;
   localparam logic [31:0] MILES_Q32 = 32'd2668768948;
   localparam logic [31:0] NAUT_Q32  = 32'd2319096810;
   localparam logic [30:0] DIST_MAX  = 31'h7FFF_FFFF;

   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef enum logic [1:0] {
      UNIT_KM      = 2'd0,
      UNIT_MILE    = 2'd1,
      UNIT_NAUT    = 2'd2,
      UNIT_INVALID = 2'd3
   } unit_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               neg_cos;
   } rot_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } vec_type;

   typedef struct packed {
      logic [60:0]        rem;
      logic [60:0]        root;
      logic signed [31:0] cosv;
   } sqrt_type;

endpackage

`default_nettype wire

FILE: rtl/core/gcd_req_if.sv
// Request channel carrying one pair of positions.
`default_nettype none

interface gcd_req_if;
   logic               valid;
   logic               ready;
   logic signed [29:0] first_latitude;
   logic signed [30:0] first_longitude;
   logic signed [29:0] second_latitude;
   logic signed [30:0] second_longitude;

   modport source (output valid, first_latitude, first_longitude, second_latitude,
                   second_longitude, input ready);
   modport sink (input valid, first_latitude, first_longitude, second_latitude,
                 second_longitude, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gcd_rsp_if.sv
// Response channel carrying one distance result.
`default_nettype none

interface gcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] distance_out;
   logic        unit_invalid;

   modport source (output valid, distance_out, unit_invalid, input ready);
   modport sink (input valid, distance_out, unit_invalid, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gcd_rot_cell.sv
// One rotation-mode CORDIC step with its output register.
`default_nettype none

module gcd_rot_cell
   import gcd_pkg::*;
#(
   parameter int Stage = 0
) (
   input  wire logic    clock,
   input  wire logic    advance,
   input  rot_type      cell_in,
   output rot_type      cell_out
);

   rot_type            stage_in;
   rot_type            stage_ff;
   logic signed [33:0] dx;
   logic signed [33:0] dy;
   logic signed [33:0] da;

   always_comb begin
      dx = cell_in.y >>> Stage;
      dy = cell_in.x >>> Stage;
      da = signed'({2'b00, ATAN_Q30[Stage]});
      stage_in = cell_in;
      if (!cell_in.z[33]) begin
         stage_in.x = cell_in.x - dx;
         stage_in.y = cell_in.y + dy;
         stage_in.z = cell_in.z - da;
      end else begin
         stage_in.x = cell_in.x + dx;
         stage_in.y = cell_in.y - dy;
         stage_in.z = cell_in.z + da;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;

endmodule

`default_nettype wire

FILE: rtl/core/gcd_vec_cell.sv
// One vectoring-mode CORDIC step with its output register.
`default_nettype none

module gcd_vec_cell
   import gcd_pkg::*;
#(
   parameter int Stage = 0
) (
   input  wire logic    clock,
   input  wire logic    advance,
   input  vec_type      cell_in,
   output vec_type      cell_out
);

   vec_type            stage_in;
   vec_type            stage_ff;
   logic signed [33:0] dx;
   logic signed [33:0] dy;
   logic signed [33:0] da;

   always_comb begin
      dx = cell_in.y >>> Stage;
      dy = cell_in.x >>> Stage;
      da = signed'({2'b00, ATAN_Q30[Stage]});
      if (!cell_in.y[33]) begin
         stage_in.x = cell_in.x + dx;
         stage_in.y = cell_in.y - dy;
         stage_in.z = cell_in.z + da;
      end else begin
         stage_in.x = cell_in.x - dx;
         stage_in.y = cell_in.y + dy;
         stage_in.z = cell_in.z - da;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;

endmodule

`default_nettype wire

FILE: rtl/core/gcd_sqrt_cell.sv
// One restoring square-root step (one result bit) with its output register.
`default_nettype none

module gcd_sqrt_cell
   import gcd_pkg::*;
#(
   parameter int BitPos = 0
) (
   input  wire logic    clock,
   input  wire logic    advance,
   input  sqrt_type     cell_in,
   output sqrt_type     cell_out
);

   localparam logic [60:0] BitVal = 61'(1) << BitPos;

   sqrt_type    stage_in;
   sqrt_type    stage_ff;
   logic [60:0] trial;

   always_comb begin
      trial = cell_in.root + BitVal;
      stage_in = cell_in;
      if (cell_in.rem >= trial) begin
         stage_in.rem  = cell_in.rem - trial;
         stage_in.root = (cell_in.root >> 1) + BitVal;
      end else begin
         stage_in.root = cell_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;

endmodule

`default_nettype wire

FILE: rtl/core/great_circle_distance_unit.sv
// Top level: pipelined great-circle distance by the spherical law of cosines.
//
// Usage: present a pair of positions (degrees, 22 fraction bits) as one
// transaction on req_chan; one transaction later leaves on rsp_chan with the
// distance (16 fraction bits) in the unit held in the csr register.
// csr_write_enable/csr_write_data set the unit: 0 km, 1 statute miles,
// 2 nautical miles, 3 invalid (distance 0, unit_invalid set). Write it only
// while no transaction is in flight.
// Throughput: one transaction per cycle while the pipeline does not stall.
// The pipeline holds three rotation CORDIC chains in parallel, a 31-cell
// square-root chain and a vectoring CORDIC chain, plus fifteen fold,
// multiply and scaling stages.
// Stall: all stages advance together; when the output register holds an
// untaken result and rsp_chan.ready is low, the pipeline holds and
// req_chan.ready drops. Nothing is lost or repeated.
// Reset: clears the valid bits and sets the unit to kilometres.
`default_nettype none

module great_circle_distance_unit
   import gcd_pkg::*;
#(
   parameter int TRIG_ITERATIONS = TrigIterationsDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   gcd_req_if.sink          req_chan,
   gcd_rsp_if.source        rsp_chan,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_write_data
);

   localparam int Latency = 2 * TRIG_ITERATIONS + SqrtSteps + 15;

   typedef struct packed {
      logic [28:0] mag;
      logic        neg;
      logic        neg_cos;
   } fold_type;

   // Reduce to [-180,180), then fold into [-90,90] and flag a negated cosine.
   function automatic fold_type fold_angle(input logic signed [31:0] ang);
      logic signed [32:0] a;
      fold_type           f;
      a = 33'(ang);
      f.neg_cos = 1'b0;
      if (a >= DEG_HALF) begin
         a = a - DEG_FULL;
      end else if (a < -DEG_HALF) begin
         a = a + DEG_FULL;
      end
      if (a > DEG_QUARTER) begin
         a = DEG_HALF - a;
         f.neg_cos = 1'b1;
      end else if (a < -DEG_QUARTER) begin
         a = -DEG_HALF - a;
         f.neg_cos = 1'b1;
      end
      f.neg = a[32];
      f.mag = a[32] ? 29'(-a) : 29'(a);
      return f;
   endfunction

   logic                 advance;
   logic [Latency-1:0]   valid_ff;
   unit_type             unit_ff;

   logic signed [31:0]   angle_ff [3];
   fold_type             fold_ff [3];
   logic [60:0]          prod_ff [3];
   fold_type             fold2_ff [3];
   rot_type              rot_chain [3][TRIG_ITERATIONS+1];
   logic signed [31:0]   sin_ff [3];
   logic signed [31:0]   cos_ff [3];
   logic [61:0]          z_rnd [3];
   logic [31:0]          z_mag [3];

   logic signed [63:0]   m_ss_ff;
   logic signed [63:0]   m_cc_ff;
   logic signed [31:0]   cd_ff;
   logic signed [31:0]   cd2_ff;
   logic signed [33:0]   ss_ff;
   logic signed [33:0]   ss2_ff;
   logic signed [31:0]   cc_ff;
   logic signed [63:0]   m3_ff;
   logic signed [34:0]   sum_in;
   logic signed [31:0]   sum_ff;
   logic [31:0]          op_a;
   logic [31:0]          op_b;
   logic [63:0]          rad_full;
   logic [60:0]          rad_ff;
   logic signed [31:0]   cos_sum_ff;
   sqrt_type             sqrt_chain [SqrtSteps+1];
   vec_type              vec_chain [TRIG_ITERATIONS+1];
   logic [31:0]          theta_ff;
   logic [60:0]          kmf_ff;
   logic [61:0]          km_rnd;
   logic [30:0]          km_in;
   logic [30:0]          km_ff;
   logic [30:0]          km2_ff;
   logic [62:0]          conv_ff;
   unit_type             unit2_ff;
   logic [63:0]          conv_rnd;
   logic [30:0]          conv_in;
   logic [30:0]          dist_in;
   logic                 invalid_in;
   logic [30:0]          dist_ff;
   logic                 invalid_ff;

   // Hold everything while the output register waits on the receiver.
   assign advance        = !valid_ff[Latency-1] || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         unit_ff  <= UNIT_KM;
      end else begin
         if (advance) begin
            valid_ff <= {valid_ff[Latency-2:0], req_chan.valid};
         end
         if (csr_write_enable) begin
            unit_ff <= unit_type'(csr_write_data);
         end
      end
   end

   // Capture latitudes and the longitude difference.
   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff[0] <= 32'(req_chan.first_latitude);
         angle_ff[1] <= 32'(req_chan.second_latitude);
         angle_ff[2] <= 32'(req_chan.second_longitude) - 32'(req_chan.first_longitude);
      end
   end

   // Three angle lanes: fold, scale to radians, rotate.
   for (genvar l = 0; l < 3; l++) begin : g_lane
      always_comb begin
         z_rnd[l] = 62'(prod_ff[l]) + 62'(64'h8000_0000);
         z_mag[l] = 32'({fold2_ff[l].mag, 2'b00}) + 32'(z_rnd[l][61:32]);
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            fold_ff[l]  <= fold_angle(angle_ff[l]);
            prod_ff[l]  <= fold_ff[l].mag * DEG2RAD_LO;
            fold2_ff[l] <= fold_ff[l];
         end
      end

      // Radian angle enters the chain as a register of its own.
      always_ff @(posedge clock) begin
         if (advance) begin
            rot_chain[l][0].x       <= CORDIC_GAIN_Q30;
            rot_chain[l][0].y       <= '0;
            rot_chain[l][0].z       <= fold2_ff[l].neg ? -signed'(34'(z_mag[l]))
                                                       : signed'(34'(z_mag[l]));
            rot_chain[l][0].neg_cos <= fold2_ff[l].neg_cos;
         end
      end

      for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_rot
         gcd_rot_cell #(.Stage(i)) u_cell (
            .clock    (clock),
            .advance  (advance),
            .cell_in  (rot_chain[l][i]),
            .cell_out (rot_chain[l][i+1])
         );
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sin_ff[l] <= 32'(rot_chain[l][TRIG_ITERATIONS].y);
            cos_ff[l] <= rot_chain[l][TRIG_ITERATIONS].neg_cos
                         ? 32'(-rot_chain[l][TRIG_ITERATIONS].x)
                         : 32'(rot_chain[l][TRIG_ITERATIONS].x);
         end
      end
   end

   // Cosine sum: s1*s2 + (c1*c2)*cd, clamped to [-1,1].
   always_comb begin
      sum_in = 35'(ss2_ff) + 35'(m3_ff >>> 30);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_ss_ff <= sin_ff[0] * sin_ff[1];
         m_cc_ff <= cos_ff[0] * cos_ff[1];
         cd_ff   <= cos_ff[2];
         ss_ff   <= 34'(m_ss_ff >>> 30);
         cc_ff   <= 32'(m_cc_ff >>> 30);
         cd2_ff  <= cd_ff;
         m3_ff   <= cc_ff * cd2_ff;
         ss2_ff  <= ss_ff;
         if (sum_in > 35'(ONE_Q30)) begin
            sum_ff <= 32'(ONE_Q30);
         end else if (sum_in < -35'(ONE_Q30)) begin
            sum_ff <= 32'(-ONE_Q30);
         end else begin
            sum_ff <= 32'(sum_in);
         end
      end
   end

   // Radicand (1-c)(1+c) for the sine of the central angle.
   always_comb begin
      op_a     = 32'(ONE_Q30 - 33'(sum_ff));
      op_b     = 32'(ONE_Q30 + 33'(sum_ff));
      rad_full = 64'(op_a) * 64'(op_b);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff     <= rad_full[60:0];
         cos_sum_ff <= sum_ff;
      end
   end

   assign sqrt_chain[0].rem  = rad_ff;
   assign sqrt_chain[0].root = '0;
   assign sqrt_chain[0].cosv = cos_sum_ff;

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      gcd_sqrt_cell #(.BitPos(2 * (SqrtSteps - 1 - k))) u_cell (
         .clock    (clock),
         .advance  (advance),
         .cell_in  (sqrt_chain[k]),
         .cell_out (sqrt_chain[k+1])
      );
   end

   // Acos start vector; a negative cosine starts a quarter turn on.
   always_comb begin
      if (sqrt_chain[SqrtSteps].cosv[31]) begin
         vec_chain[0].x = signed'(34'(sqrt_chain[SqrtSteps].root[30:0]));
         vec_chain[0].y = -34'(sqrt_chain[SqrtSteps].cosv);
         vec_chain[0].z = HALF_PI_Q30;
      end else begin
         vec_chain[0].x = 34'(sqrt_chain[SqrtSteps].cosv);
         vec_chain[0].y = signed'(34'(sqrt_chain[SqrtSteps].root[30:0]));
         vec_chain[0].z = '0;
      end
   end

   for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_vec
      gcd_vec_cell #(.Stage(i)) u_cell (
         .clock    (clock),
         .advance  (advance),
         .cell_in  (vec_chain[i]),
         .cell_out (vec_chain[i+1])
      );
   end

   // Scale the central angle by the radius, then convert the unit.
   always_comb begin
      km_rnd = 62'(kmf_ff) + 62'(64'h2000_0000);
      km_in  = (km_rnd[61:30] > 32'(DIST_MAX)) ? DIST_MAX : km_rnd[60:30];

      conv_rnd = 64'(conv_ff) + 64'h8000_0000;
      conv_in  = (conv_rnd[63:32] > 32'(DIST_MAX)) ? DIST_MAX : conv_rnd[62:32];

      dist_in    = km2_ff;
      invalid_in = 1'b0;
      unique case (unit2_ff)
         UNIT_KM:   dist_in = km2_ff;
         UNIT_MILE: dist_in = conv_in;
         UNIT_NAUT: dist_in = conv_in;
         UNIT_INVALID: begin
            dist_in    = '0;
            invalid_in = 1'b1;
         end
         default: begin
            dist_in    = '0;
            invalid_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         theta_ff   <= vec_chain[TRIG_ITERATIONS].z[33] ? '0
                                                        : vec_chain[TRIG_ITERATIONS].z[31:0];
         kmf_ff     <= theta_ff * RADIUS_KM_Q16;
         km_ff      <= km_in;
         conv_ff    <= km_ff * ((unit_ff == UNIT_MILE) ? MILES_Q32 : NAUT_Q32);
         km2_ff     <= km_ff;
         unit2_ff   <= unit_ff;
         dist_ff    <= dist_in;
         invalid_ff <= invalid_in;
      end
   end

   assign rsp_chan.valid        = valid_ff[Latency-1];
   assign rsp_chan.distance_out = dist_ff;
   assign rsp_chan.unit_invalid = invalid_ff;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the great-circle distance unit.
`default_nettype none

module tb_top;
   import gcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  ITERATIONS   = TrigIterationsDef;
   localparam int  LATENCY      = 2 * ITERATIONS + 46;
   localparam int  CYCLE_LIMIT  = 600000;
   localparam int  MAX_WAIT     = 17;
   localparam longint LAT_SPAN  = 377487360;
   localparam longint LON_SPAN  = 754974720;
   localparam longint ONE       = 1073741824;
   localparam longint HALF_PI   = 1686629713;
   localparam longint GAIN      = 652032874;
   localparam longint QUARTER   = 377487360;
   localparam longint HALF_TURN = 754974720;
   localparam longint FULL_TURN = 1509949440;
   localparam bit [63:0] TO_RAD = 64'd19190098069;
   localparam bit [63:0] RADIUS = 64'd417997586;
   localparam bit [63:0] MILES  = 64'd2668768948;
   localparam bit [63:0] NAUT   = 64'd2319096810;
   localparam bit [63:0] CEIL   = 64'd2147483647;

   typedef struct {
      logic [30:0] distance;
      logic        invalid;
   } distance_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_write_data = UNIT_KM;

   gcd_req_if req_chan ();
   gcd_rsp_if rsp_chan ();

   great_circle_distance_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   distance_result_type pending_distances[$];
   unit_type       active_unit = UNIT_KM;
   int             error_count = 0;
   int             cycle_count = 0;
   bit             send_busy   = 1'b1;  // no gaps while set
   bit             recv_busy   = 1'b1;

   always #1 clock = ~clock;

   // Kill a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   // Fold the angle into [-90,90] degrees and run the rotation CORDIC.
   function automatic void rotate_angle(input longint deg, output longint sin_q30,
                                        output longint cos_q30);
      longint a, z, x, y, dx, dy;
      bit flip;
      bit [63:0] mag;
      a = deg % FULL_TURN;
      flip = 1'b0;
      x = GAIN;
      y = 0;
      if (a >= HALF_TURN) a -= FULL_TURN;
      if (a < -HALF_TURN) a += FULL_TURN;
      if (a > QUARTER) begin
         a = HALF_TURN - a;
         flip = 1'b1;
      end else if (a < -QUARTER) begin
         a = -HALF_TURN - a;
         flip = 1'b1;
      end
      mag = (a < 0) ? -a : a;
      z = longint'((mag * TO_RAD + 64'h8000_0000) >> 32);
      if (a < 0) z = -z;
      for (int i = 0; i < ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
         end
      end
      sin_q30 = y;
      cos_q30 = flip ? -x : x;
   endfunction

   function automatic bit [63:0] root_floor(input bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Vectoring CORDIC for the central angle; negative arguments start at pi/2.
   function automatic longint central_angle(input longint c);
      bit [63:0] rad;
      longint sq, x, y, z, dx, dy;
      rad = (ONE - c) * (ONE + c);
      sq = longint'(root_floor(rad));
      if (c < 0) begin
         x = sq; y = -c; z = HALF_PI;
      end else begin
         x = c; y = sq; z = 0;
      end
      for (int i = 0; i < ITERATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
         end else begin
            x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
         end
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic distance_result_type predict_distance(input longint lat1, lon1,
                                                            lat2, lon2);
      longint s1, c1, s2, c2, sd, cd, sum;
      bit [63:0] km, dist_val;
      distance_result_type r;
      rotate_angle(lat1, s1, c1);
      rotate_angle(lat2, s2, c2);
      rotate_angle(lon2 - lon1, sd, cd);
      sum = ((s1 * s2) >>> 30) + ((((c1 * c2) >>> 30) * cd) >>> 30);
      if (sum > ONE) sum = ONE;
      if (sum < -ONE) sum = -ONE;
      km = (64'(central_angle(sum)) * RADIUS + (64'd1 << 29)) >> 30;
      if (km > CEIL) km = CEIL;
      case (active_unit)
         UNIT_KM:   dist_val = km;
         UNIT_MILE: dist_val = (km * MILES + 64'h8000_0000) >> 32;
         UNIT_NAUT: dist_val = (km * NAUT + 64'h8000_0000) >> 32;
         default:   dist_val = 0;
      endcase
      if (dist_val > CEIL) dist_val = CEIL;
      r.distance = dist_val[30:0];
      r.invalid  = (active_unit == UNIT_INVALID);
      return r;
   endfunction

   // ---------------- request side ----------------

   function automatic longint draw_coord(input longint span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Enter at a rising edge (or at start); leave on the edge that took the transaction.
   task automatic send_positions(input longint lat1, lon1, lat2, lon2);
      int gap;
      @(negedge clock);
      gap = send_busy ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.first_latitude   = lat1[29:0];
      req_chan.first_longitude  = lon1[30:0];
      req_chan.second_latitude  = lat2[29:0];
      req_chan.second_longitude = lon2[30:0];
      req_chan.valid = 1'b1;
      // Predict from the wrapped values the block actually sees.
      pending_distances.push_back(predict_distance(
         longint'(req_chan.first_latitude), longint'(req_chan.first_longitude),
         longint'(req_chan.second_latitude), longint'(req_chan.second_longitude)));
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_chan.valid = 1'b0;
      wait (pending_distances.size() == 0);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   // Change the unit only with the pipeline empty.
   task automatic write_unit(input unit_type u);
      drain_pipeline();
      csr_write_enable = 1'b1;
      csr_write_data   = u;
      @(negedge clock);
      csr_write_enable = 1'b0;
      active_unit = u;
   endtask

   // ---------------- response side ----------------

   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = recv_busy ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // Compare each transaction with the oldest expectation.
   always @(posedge clock) begin
      distance_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_distances.size() == 0) begin
            $display("%0t: unexpected result distance=%0d invalid=%0b", $realtime,
                     rsp_chan.distance_out, rsp_chan.unit_invalid);
            error_count++;
         end else begin
            want = pending_distances.pop_front();
            if (rsp_chan.distance_out !== want.distance) begin
               $display("%0t: distance expected %0d actual %0d", $realtime,
                        want.distance, rsp_chan.distance_out);
               error_count++;
            end
            if (rsp_chan.unit_invalid !== want.invalid) begin
               $display("%0t: unit_invalid expected %0b actual %0b", $realtime,
                        want.invalid, rsp_chan.unit_invalid);
               error_count++;
            end
         end
      end
   end

   // ---------------- tests ----------------

   // Poles, date line, identical and antipodal points, wrapped raw codes.
   task automatic test_corner_positions();
      send_positions(0, 0, 0, 0);
      send_positions(LAT_SPAN, 0, -LAT_SPAN, 0);
      send_positions(LAT_SPAN, LON_SPAN, LAT_SPAN, -LON_SPAN);
      send_positions(0, -LON_SPAN, 0, LON_SPAN);
      send_positions(0, 0, 0, LON_SPAN);
      send_positions(-LAT_SPAN, -LON_SPAN, LAT_SPAN, LON_SPAN);
      send_positions(12345678, 98765432, 12345678, 98765432);
      send_positions(100000000, 200000000, -100000000, 200000000 - LON_SPAN);
      send_positions(LAT_SPAN, 0, LAT_SPAN - 1, 1);
      send_positions(0, 0, 0, 1);
      send_positions(-(longint'(1) << 29), -(longint'(1) << 30),
                     (longint'(1) << 29) - 1, (longint'(1) << 30) - 1);
      send_positions((longint'(1) << 29) - 1, (longint'(1) << 30) - 1,
                     -(longint'(1) << 29), -(longint'(1) << 30));
      send_positions(-1, -1, -1, 0);
   endtask

   // Run a few pairs through one unit, including the longest path and a zero distance.
   task automatic test_unit(input unit_type u);
      write_unit(u);
      send_positions(0, 0, 0, LON_SPAN);
      send_positions(LAT_SPAN, 0, -LAT_SPAN, 0);
      send_positions(0, 0, 0, 0);
      send_positions(draw_coord(LAT_SPAN), draw_coord(LON_SPAN),
                     draw_coord(LAT_SPAN), draw_coord(LON_SPAN));
   endtask

   task automatic test_random_positions(input int count);
      longint lat1, lon1, lat2, lon2;
      for (int n = 0; n < count; n++) begin
         if (n % 150 == 0) begin
            send_busy = ($urandom_range(0, 3) == 0);
            recv_busy = ($urandom_range(0, 3) == 0);
         end
         lat1 = draw_coord(LAT_SPAN);
         lon1 = draw_coord(LON_SPAN);
         case ($urandom_range(0, 9))
            0: begin  // any bit pattern
               lat1 = longint'($urandom); lon1 = longint'($urandom);
               lat2 = longint'($urandom); lon2 = longint'($urandom);
            end
            1: begin  // near neighbors
               lat2 = lat1 + $urandom_range(0, 4000) - 2000;
               lon2 = lon1 + $urandom_range(0, 4000) - 2000;
            end
            2: begin  // near antipodes
               lat2 = -lat1 + $urandom_range(0, 4000) - 2000;
               lon2 = lon1 + LON_SPAN + $urandom_range(0, 4000) - 2000;
            end
            default: begin
               lat2 = draw_coord(LAT_SPAN);
               lon2 = draw_coord(LON_SPAN);
            end
         endcase
         send_positions(lat1, lon1, lat2, lon2);
         // Hold off until the pipeline empties, once mid-run.
         if (n == count / 2) begin
            @(negedge clock);
            req_chan.valid = 1'b0;
            wait (pending_distances.size() == 0);
         end
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.first_latitude   = '0;
      req_chan.first_longitude  = '0;
      req_chan.second_latitude  = '0;
      req_chan.second_longitude = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_corner_positions();
      send_busy = 1'b0;
      recv_busy = 1'b0;
      test_unit(UNIT_MILE);
      test_unit(UNIT_NAUT);
      test_unit(UNIT_INVALID);
      test_unit(UNIT_KM);
      test_random_positions(500);
      write_unit(UNIT_MILE);
      test_random_positions(400);
      write_unit(UNIT_NAUT);
      test_random_positions(400);
      write_unit(UNIT_INVALID);
      test_random_positions(100);
      write_unit(UNIT_KM);
      test_random_positions(250);

      drain_pipeline();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/gcd_pkg.sv
rtl/core/gcd_req_if.sv
rtl/core/gcd_rsp_if.sv
rtl/core/gcd_rot_cell.sv
rtl/core/gcd_vec_cell.sv
rtl/core/gcd_sqrt_cell.sv
rtl/core/great_circle_distance_unit.sv
tb/sv/tb_top.sv
